@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ sv/bale_pkg.sv @@
// ----------------------------------------------------------------------------
// bale_pkg
// Operation codes, status codes and the result word of the array list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package bale_pkg;

  localparam int OP_W     = 3;
  localparam int POS_W    = 9;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int IDX_W    = 8;
  localparam int TOTAL_W  = 9;

  localparam logic [OP_W-1:0] OP_PUSH_TAIL = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_HEAD = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_TAIL  = 3'd2;
  localparam logic [OP_W-1:0] OP_INSERT    = 3'd3;
  localparam logic [OP_W-1:0] OP_DELETE    = 3'd4;
  localparam logic [OP_W-1:0] OP_MODIFY    = 3'd5;
  localparam logic [OP_W-1:0] OP_SEARCH    = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [IDX_W-1:0]    found_index;
    logic [TOTAL_W-1:0]  element_total;
  } res_t;

endpackage

`default_nettype wire

@@ sv/bale_mem.sv @@
// ----------------------------------------------------------------------------
// bale_mem
// Element store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bale_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32,
  parameter int AW    = 8
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ sv/bale_ctrl.sv @@
// ----------------------------------------------------------------------------
// bale_ctrl
// Request sequencer: decodes a request, walks the store one element a cycle
// through a single step/compare unit for shifts and searches, builds the result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bale_ctrl #(
  parameter int CAPACITY   = 256,
  parameter int DATA_WIDTH = 32,
  parameter int AW         = 8,
  parameter int CW         = 9
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [bale_pkg::OP_W-1:0]    in_operation,
  input  wire logic [bale_pkg::POS_W-1:0]   in_position,
  input  wire logic [bale_pkg::VAL_W-1:0]   in_value,
  output logic                              res_valid,
  input  wire logic                         res_ready,
  output bale_pkg::res_t                    res,
  output logic                              wr_en,
  output logic      [AW-1:0]                wr_addr,
  output logic      [DATA_WIDTH-1:0]        wr_data,
  output logic                              rd_en,
  output logic      [AW-1:0]                rd_addr,
  input  wire logic [DATA_WIDTH-1:0]        rd_data
);

  localparam int PW = (CW > bale_pkg::POS_W) ? CW : bale_pkg::POS_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_OPEN  = 3'd1;
  localparam logic [2:0] S_FILL  = 3'd2;
  localparam logic [2:0] S_CLOSE = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]                      state_r, state_nxt;
  logic [CW-1:0]                   count_r, count_nxt;
  logic [AW-1:0]                   cur_r, cur_nxt;
  logic [AW-1:0]                   pos_r, pos_nxt;
  logic [DATA_WIDTH-1:0]           word_r, word_nxt;
  logic [bale_pkg::STATUS_W-1:0]   status_r, status_nxt;
  logic                            hit_r, hit_nxt;
  logic [AW-1:0]                   idx_r, idx_nxt;

  logic [63:0]           val_ext;
  logic [DATA_WIDTH-1:0] word_in;
  logic [PW-1:0]         pos_w;
  logic [PW-1:0]         ins_pos;
  logic [PW-1:0]         cnt_w;
  logic                  full;
  logic                  at_last;
  logic [PW-1:0]         idx_w;
  logic [PW-1:0]         total_w;

  assign val_ext = {{(64 - bale_pkg::VAL_W){in_value[bale_pkg::VAL_W-1]}}, in_value};
  assign word_in = val_ext[DATA_WIDTH-1:0];
  assign pos_w   = PW'(in_position);
  assign cnt_w   = PW'(count_r);
  assign full    = (count_r == CW'(CAPACITY));
  assign ins_pos = (in_operation == bale_pkg::OP_PUSH_HEAD) ? '0 : pos_w;
  // walker has reached the last live element
  assign at_last = (CW'(cur_r) == count_r - CW'(1));

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    cur_nxt    = cur_r;
    pos_nxt    = pos_r;
    word_nxt   = word_r;
    status_nxt = status_r;
    hit_nxt    = hit_r;
    idx_nxt    = idx_r;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = word_r;
    rd_en      = 1'b0;
    rd_addr    = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          word_nxt   = word_in;
          status_nxt = bale_pkg::ST_OK;
          hit_nxt    = 1'b0;
          idx_nxt    = '0;
          state_nxt  = S_DONE;
          case (in_operation)
            bale_pkg::OP_PUSH_TAIL: begin
              if (full) begin
                status_nxt = bale_pkg::ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = AW'(count_r);
                wr_data   = word_in;
                count_nxt = count_r + CW'(1);
              end
            end
            bale_pkg::OP_PUSH_HEAD, bale_pkg::OP_INSERT: begin
              if (ins_pos > cnt_w) begin
                status_nxt = bale_pkg::ST_RANGE;
              end else if (full) begin
                status_nxt = bale_pkg::ST_FULL;
              end else if (ins_pos == cnt_w) begin
                wr_en     = 1'b1;
                wr_addr   = AW'(ins_pos);
                wr_data   = word_in;
                count_nxt = count_r + CW'(1);
              end else begin
                // start moving the tail up, last element first
                rd_en     = 1'b1;
                rd_addr   = AW'(count_r - CW'(1));
                cur_nxt   = AW'(count_r - CW'(1));
                pos_nxt   = AW'(ins_pos);
                state_nxt = S_OPEN;
              end
            end
            bale_pkg::OP_POP_TAIL: begin
              if (count_r == '0) begin
                status_nxt = bale_pkg::ST_EMPTY;
              end else begin
                count_nxt = count_r - CW'(1);
              end
            end
            bale_pkg::OP_DELETE: begin
              if (pos_w >= cnt_w) begin
                status_nxt = bale_pkg::ST_RANGE;
              end else if (pos_w == cnt_w - PW'(1)) begin
                count_nxt = count_r - CW'(1);
              end else begin
                rd_en     = 1'b1;
                rd_addr   = AW'(pos_w + PW'(1));
                cur_nxt   = AW'(pos_w + PW'(1));
                state_nxt = S_CLOSE;
              end
            end
            bale_pkg::OP_MODIFY: begin
              if (pos_w >= cnt_w) begin
                status_nxt = bale_pkg::ST_RANGE;
              end else begin
                wr_en   = 1'b1;
                wr_addr = AW'(pos_w);
                wr_data = word_in;
              end
            end
            bale_pkg::OP_SEARCH: begin
              if (count_r != '0) begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                cur_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_OPEN: begin
        wr_en   = 1'b1;
        wr_addr = cur_r + AW'(1);
        wr_data = rd_data;
        if (cur_r == pos_r) begin
          state_nxt = S_FILL;
        end else begin
          rd_en   = 1'b1;
          rd_addr = cur_r - AW'(1);
          cur_nxt = cur_r - AW'(1);
        end
      end

      S_FILL: begin
        wr_en     = 1'b1;
        wr_addr   = pos_r;
        wr_data   = word_r;
        count_nxt = count_r + CW'(1);
        state_nxt = S_DONE;
      end

      S_CLOSE: begin
        wr_en   = 1'b1;
        wr_addr = cur_r - AW'(1);
        wr_data = rd_data;
        if (at_last) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = cur_r + AW'(1);
          cur_nxt = cur_r + AW'(1);
        end
      end

      S_SCAN: begin
        if (rd_data == word_r) begin
          hit_nxt   = 1'b1;
          idx_nxt   = cur_r;
          state_nxt = S_DONE;
        end else if (at_last) begin
          state_nxt = S_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = cur_r + AW'(1);
          cur_nxt = cur_r + AW'(1);
        end
      end

      S_DONE: begin
        // hold the result until the output register frees up
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    pos_r    <= pos_nxt;
    word_r   <= word_nxt;
    status_r <= status_nxt;
    hit_r    <= hit_nxt;
    idx_r    <= idx_nxt;
  end

  assign idx_w   = PW'(idx_r);
  assign total_w = PW'(count_r);

  assign in_ready          = (state_r == S_IDLE);
  assign res_valid         = (state_r == S_DONE);
  assign res.status        = status_r;
  assign res.found         = hit_r;
  assign res.found_index   = idx_w[bale_pkg::IDX_W-1:0];
  assign res.element_total = total_w[bale_pkg::TOTAL_W-1:0];

  `ASSERT_ALWAYS(a_count_bound, count_r <= CW'(CAPACITY), "element count above capacity")
  `ASSERT_IMPLY(a_count_step, !$stable(count_r), (count_r == $past(count_r) + CW'(1)) || (count_r + CW'(1) == $past(count_r)), "element count moved by more than one")
  `ASSERT_IMPLY(a_wr_in_list, wr_en, CW'(wr_addr) <= count_r, "store write beyond list tail")
  `ASSERT_IMPLY(a_walk_in_list, (state_r == S_SCAN) || (state_r == S_CLOSE), CW'(cur_r) < count_r, "walker outside live elements")
  `ASSERT_IMPLY(a_open_above_gap, state_r == S_OPEN, cur_r >= pos_r, "shift walked below insert position")

endmodule

`default_nettype wire

@@ sv/bounded_array_list_engine.sv @@
// ----------------------------------------------------------------------------
// bounded_array_list_engine
// Ordered list of signed words in a fixed store with an element count.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_valid/in_ready with in_operation, in_position and
//   in_value; each gives exactly one result word on out_valid/out_ready
//   (status, found flag, found index, element count after the request).
//   The block takes one request at a time; in_ready is high while idle.
//   With count n and position p: push tail, pop, modify, errors and unused
//   codes finish without walking the store; insert at p < n (push head is
//   p = 0) moves elements p..n-1 up, last first; delete at p < n - 1 moves
//   elements p+1..n-1 down; search reads from index 0 up to the first match.
//   Shifts and searches touch one stored element per cycle through the
//   single read port of the store. A finished result sits in the output
//   register; the next request is accepted while it waits. If the receiver
//   stalls, the following result is held inside until the register frees,
//   and in_ready stays low. Reset clears the element count and control
//   state; the store is not cleared, only live entries are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_array_list_engine #(
  parameter int CAPACITY   = 256,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [bale_pkg::OP_W-1:0]           in_operation,
  input  wire logic [bale_pkg::POS_W-1:0]          in_position,
  input  wire logic signed [bale_pkg::VAL_W-1:0]   in_value,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic      [bale_pkg::STATUS_W-1:0]       out_status,
  output logic                                     out_found,
  output logic      [bale_pkg::IDX_W-1:0]          out_found_index,
  output logic      [bale_pkg::TOTAL_W-1:0]        out_element_total
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic                  res_valid;
  logic                  res_ready;
  bale_pkg::res_t        res;
  bale_pkg::res_t        out_r, out_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;

  bale_ctrl #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW),
    .CW         (CW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_position  (in_position),
    .in_value     (in_value),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data)
  );

  bale_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // output register: load when empty or being drained this cycle
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_r.status;
  assign out_found         = out_r.found;
  assign out_found_index   = out_r.found_index;
  assign out_element_total = out_r.element_total;

endmodule

`default_nettype wire
